// ===== hw/rtl/tfp_pkg.sv =====
// Package for the tagged frame parser: codes, tag texts and shared types.
package tfp_pkg;

  localparam int unsigned WinLen  = 5;
  localparam int unsigned NumTags = 8;

  // Parser phase; the unused code falls back to hunting.
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_TRAILER = 2'd2
  } phase_e;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_NO_MATCH = 3'd0,
    EV_TAG      = 3'd1,
    EV_PAYLOAD  = 3'd2,
    EV_TRAILER  = 3'd3,
    EV_ACK      = 3'd4,
    EV_ERROR    = 3'd5,
    EV_BUSY     = 3'd6,
    EV_RELEASED = 3'd7
  } event_e;

  typedef logic [3:0] msg_type_t;

  localparam msg_type_t MT_NONE       = 4'd0;
  localparam msg_type_t MT_REQUEST    = 4'd1;
  localparam msg_type_t MT_IDENT      = 4'd2;
  localparam msg_type_t MT_LEDMANAGER = 4'd3;
  localparam msg_type_t MT_PANEL      = 4'd4;
  localparam msg_type_t MT_DIODE      = 4'd5;
  localparam msg_type_t MT_PALETTE    = 4'd6;
  localparam msg_type_t MT_SLEEP      = 4'd7;
  localparam msg_type_t MT_LIGHT      = 4'd8;

  // Five-byte window, oldest byte in the top bits.
  typedef logic [8*WinLen-1:0] window_t;

  // Tag texts; entry i selects message type i+1.
  localparam window_t TagText [NumTags] = '{
    window_t'("Reque"), window_t'("Ident"), window_t'("LedMa"), window_t'("Panel"),
    window_t'("Diode"), window_t'("Custo"), window_t'("Sleep"), window_t'("Light")
  };

  localparam window_t TrailerText = window_t'("Clear");

  // Kind flag on the input stream.
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

endpackage

// ===== hw/rtl/tagged_frame_parser_core.sv =====
// Tagged frame parser: tag hunt, payload pass-through, trailer check, hold.
//
//  channel   dir  tdata (low bit up)                          tuser
//  s_axis    in   rx_byte[7:0]                                kind (0 byte, 1 release)
//  m_axis    out  msg_type[3:0] payload_index[9:4]            event_res[2:0]
//                 payload_byte[17:10] held_type[21:18] pad
//
// Cycles: one item per cycle while results are taken; each accepted item gives one
//   result item in the output register on the next edge. The tag compare, count
//   and trailer check sit between the parser state and that register.
// Reset: rst_ni clears window, phase, type, count, held type and output valid.
// Stalls: the output register holds until taken; a new item is accepted in the
//   same cycle the held result leaves, so tready drops only on a stalled result.
module tagged_frame_parser_core #(
  parameter int unsigned PALETTE_COLOURS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  input  logic        s_axis_tuser_i,   // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // msg_type, payload_index, payload_byte, held_type
  output logic [2:0]  m_axis_tuser_o    // event_res
);

  // Longest payload is the palette; the count must reach it and the trailer length.
  localparam int unsigned PalLen = 1 + 3 * PALETTE_COLOURS;
  localparam int unsigned MaxLen = (PalLen > tfp_pkg::WinLen) ? PalLen : tfp_pkg::WinLen;
  localparam int unsigned CntW   = $clog2(MaxLen + 1);

  typedef logic [CntW-1:0] count_t;

  // Payload length per message type; zero for types without payload.
  function automatic count_t payload_len(tfp_pkg::msg_type_t t);
    count_t len;
    len = '0;
    unique case (t)
      tfp_pkg::MT_LEDMANAGER: len = count_t'(2);
      tfp_pkg::MT_PANEL:      len = count_t'(5);
      tfp_pkg::MT_DIODE:      len = count_t'(6);
      tfp_pkg::MT_PALETTE:    len = count_t'(PalLen);
      tfp_pkg::MT_SLEEP:      len = count_t'(4);
      tfp_pkg::MT_LIGHT:      len = count_t'(1);
      default:                len = '0;
    endcase
    return len;
  endfunction

  // Parser state
  tfp_pkg::window_t   win_q, win_d;
  tfp_pkg::phase_e    phase_q, phase_d;
  tfp_pkg::msg_type_t frame_q, frame_d;
  count_t             cnt_q, cnt_d;
  tfp_pkg::msg_type_t held_q, held_d;

  // Output register
  logic               out_valid_q;
  tfp_pkg::event_e    ev_q, ev_d;
  tfp_pkg::msg_type_t mt_q, mt_d;
  logic [5:0]         idx_q, idx_d;
  logic [7:0]         pb_q, pb_d;

  logic               s_accept;
  tfp_pkg::window_t   win_shift;
  count_t             cnt_inc;
  tfp_pkg::msg_type_t tag_hit;

  // Accept whenever the output register is empty or leaving this cycle.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign win_shift = {win_q[8*tfp_pkg::WinLen-9:0], s_axis_tdata_i};
  assign cnt_inc   = cnt_q + count_t'(1);

  // Tag compare on the window after the shift; first match wins.
  always_comb begin
    tag_hit = tfp_pkg::MT_NONE;
    for (int i = tfp_pkg::NumTags - 1; i >= 0; i--) begin
      if (win_shift == tfp_pkg::TagText[i]) begin
        tag_hit = tfp_pkg::msg_type_t'(i + 1);
      end
    end
  end

  // Next state and result for the item at the input.
  always_comb begin
    win_d   = win_q;
    phase_d = phase_q;
    frame_d = frame_q;
    cnt_d   = cnt_q;
    held_d  = held_q;
    ev_d    = tfp_pkg::EV_NO_MATCH;
    mt_d    = tfp_pkg::MT_NONE;
    idx_d   = '0;
    pb_d    = '0;
    priority if (s_axis_tuser_i == tfp_pkg::KIND_RELEASE) begin
      ev_d   = tfp_pkg::EV_RELEASED;
      mt_d   = held_q;
      held_d = tfp_pkg::MT_NONE;
    end else if (held_q != tfp_pkg::MT_NONE) begin
      // Drop the byte while a frame is held.
      ev_d = tfp_pkg::EV_BUSY;
    end else begin
      unique case (phase_q)
        tfp_pkg::PH_PAYLOAD: begin
          // Payload bypasses the window.
          ev_d  = tfp_pkg::EV_PAYLOAD;
          mt_d  = frame_q;
          idx_d = 6'(cnt_q);
          pb_d  = s_axis_tdata_i;
          cnt_d = cnt_inc;
          if (cnt_inc >= payload_len(frame_q)) begin
            phase_d = tfp_pkg::PH_TRAILER;
            cnt_d   = '0;
          end
        end
        tfp_pkg::PH_TRAILER: begin
          win_d = win_shift;
          mt_d  = frame_q;
          cnt_d = cnt_inc;
          if (cnt_inc >= count_t'(tfp_pkg::WinLen)) begin
            if (win_shift == tfp_pkg::TrailerText) begin
              ev_d   = tfp_pkg::EV_ACK;
              held_d = frame_q;
            end else begin
              ev_d = tfp_pkg::EV_ERROR;
            end
            phase_d = tfp_pkg::PH_HUNT;
            cnt_d   = '0;
          end else begin
            ev_d = tfp_pkg::EV_TRAILER;
          end
        end
        default: begin
          // Hunting; the unused phase code lands here too.
          phase_d = tfp_pkg::PH_HUNT;
          win_d   = win_shift;
          if (tag_hit != tfp_pkg::MT_NONE) begin
            ev_d    = tfp_pkg::EV_TAG;
            mt_d    = tag_hit;
            frame_d = tag_hit;
            cnt_d   = '0;
            phase_d = (payload_len(tag_hit) != '0) ? tfp_pkg::PH_PAYLOAD
                                                   : tfp_pkg::PH_TRAILER;
          end
        end
      endcase
    end
  end

  // Parser state advances only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      phase_q <= tfp_pkg::PH_HUNT;
      frame_q <= tfp_pkg::MT_NONE;
      cnt_q   <= '0;
      held_q  <= tfp_pkg::MT_NONE;
    end else if (s_accept) begin
      win_q   <= win_d;
      phase_q <= phase_d;
      frame_q <= frame_d;
      cnt_q   <= cnt_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; the held type is the one after the step.
  tfp_pkg::msg_type_t held_out_q;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      ev_q       <= ev_d;
      mt_q       <= mt_d;
      idx_q      <= idx_d;
      pb_q       <= pb_d;
      held_out_q <= held_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = ev_q;
  assign m_axis_tdata_o  = {2'b00, held_out_q, pb_q, idx_q, mt_q};

  // A held frame only exists after a completed trailer, so hunting resumes.
  a_held_in_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != tfp_pkg::MT_NONE |-> phase_q == tfp_pkg::PH_HUNT)
    else $error("held frame outside hunt phase");

  a_trailer_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tfp_pkg::PH_TRAILER |-> cnt_q < count_t'(tfp_pkg::WinLen))
    else $error("trailer count overran the window");

  a_payload_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tfp_pkg::PH_PAYLOAD |-> payload_len(frame_q) != '0)
    else $error("payload phase for a type without payload");

  a_busy_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && s_axis_tuser_i == tfp_pkg::KIND_BYTE && held_q != tfp_pkg::MT_NONE
    |=> out_valid_q && ev_q == tfp_pkg::EV_BUSY && $stable(win_q))
    else $error("byte not rejected while a frame is held");

endmodule
